// ===== rtl/lfu_pkg.sv =====
package lfu_pkg;

	localparam int ENTRIES    = 16;
	localparam int COUNT_BITS = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int DATA_BITS  = KEY_BITS + VALUE_BITS;
	localparam int CAP_BITS   = 5;
	localparam int CAP_RESET  = 16;
	localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int USED_BITS  = $clog2(ENTRIES + 1);

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	localparam logic [1:0] OP_NONE   = 2'd0;
	localparam logic [1:0] OP_HIT    = 2'd1;
	localparam logic [1:0] OP_INSERT = 2'd2;

	typedef struct packed {
		logic                  found;
		logic [IDX_BITS-1:0]   found_idx;
		logic [IDX_BITS-1:0]   found_rank;
		logic [VALUE_BITS-1:0] found_value;
		logic [USED_BITS-1:0]  used;
		logic                  best_ok;
		logic [IDX_BITS-1:0]   best_idx;
		logic [IDX_BITS-1:0]   best_rank;
		logic [COUNT_BITS-1:0] best_cnt;
		logic [KEY_BITS-1:0]   best_key;
		logic                  free_ok;
		logic [IDX_BITS-1:0]   free_idx;
	} scan_t;

	typedef struct packed {
		logic [1:0]            op;
		logic [IDX_BITS-1:0]   slot;
		logic [USED_BITS-1:0]  old_rank;
		logic                  wr_value;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} upd_t;

endpackage

// ===== rtl/lfu_cell.sv =====
module lfu_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [lfu_pkg::IDX_BITS-1:0]   idx,
	input  logic [lfu_pkg::KEY_BITS-1:0]   req_key,
	input  lfu_pkg::scan_t                 scan_in,
	output lfu_pkg::scan_t                 scan_out,
	input  lfu_pkg::upd_t                  upd
);

	localparam int UB = lfu_pkg::USED_BITS;
	localparam int CB = lfu_pkg::COUNT_BITS;

	logic                             valid_q;
	logic [lfu_pkg::KEY_BITS-1:0]     key_q;
	logic [lfu_pkg::VALUE_BITS-1:0]   value_q;
	logic [CB-1:0]                    cnt_q;
	logic [lfu_pkg::IDX_BITS-1:0]     rank_q;
	lfu_pkg::scan_t                   scan_q;
	lfu_pkg::scan_t                   scan_nxt;
	logic [UB-1:0]                    rank_ext;
	logic                             is_slot;

	assign rank_ext = UB'(rank_q);
	assign is_slot  = (upd.slot == idx);
	assign scan_out = scan_q;

	always_comb begin
		scan_nxt = scan_in;
		if (valid_q) begin
			scan_nxt.used = scan_in.used + 1'b1;
		end
		if (valid_q && key_q == req_key && !scan_in.found) begin
			scan_nxt.found       = 1'b1;
			scan_nxt.found_idx   = idx;
			scan_nxt.found_rank  = rank_q;
			scan_nxt.found_value = value_q;
		end
		if (valid_q && (!scan_in.best_ok || cnt_q < scan_in.best_cnt ||
				(cnt_q == scan_in.best_cnt && rank_q > scan_in.best_rank))) begin
			scan_nxt.best_ok   = 1'b1;
			scan_nxt.best_idx  = idx;
			scan_nxt.best_rank = rank_q;
			scan_nxt.best_cnt  = cnt_q;
			scan_nxt.best_key  = key_q;
		end
		if (!valid_q && !scan_in.free_ok) begin
			scan_nxt.free_ok  = 1'b1;
			scan_nxt.free_idx = idx;
		end
	end

	always_ff @(posedge clk) begin
		scan_q <= scan_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (upd.op == lfu_pkg::OP_INSERT && is_slot) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (upd.op)
			lfu_pkg::OP_HIT: begin
				if (is_slot) begin
					rank_q <= '0;
					if (cnt_q != {CB{1'b1}}) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (upd.wr_value) begin
						value_q <= upd.value;
					end
				end else if (valid_q && rank_ext < upd.old_rank) begin
					rank_q <= rank_q + 1'b1;
				end
			end
			lfu_pkg::OP_INSERT: begin
				if (is_slot) begin
					rank_q  <= '0;
					cnt_q   <= CB'(1);
					key_q   <= upd.key;
					value_q <= upd.value;
				end else if (valid_q && rank_ext < upd.old_rank) begin
					rank_q <= rank_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/lfu_cache_table.sv =====
// A request is accepted only in the idle state; it is then scanned and committed before the next one.
// The commit waits while the output register holds a result that has not been taken.
// The scan walks the row of cells one cell per cycle.
// A result may wait in the output register while the next request is accepted.
// Reset clears all valid marks, sets capacity to 16 and empties the output register.
module lfu_cache_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [lfu_pkg::CAP_BITS-1:0]    cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lfu_pkg::DATA_BITS-1:0]   s_tdata,  // key, value
	input  logic                            s_tuser,  // cmd
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lfu_pkg::DATA_BITS-1:0]   m_tdata,  // read_value, evicted_key
	output logic [1:0]                      m_tuser   // hit, evicted
);

	localparam int UB = lfu_pkg::USED_BITS;
	localparam int IB = lfu_pkg::IDX_BITS;
	localparam int KB = lfu_pkg::KEY_BITS;
	localparam int VB = lfu_pkg::VALUE_BITS;
	localparam int NE = lfu_pkg::ENTRIES;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	logic [1:0]                     state_q;
	logic [IB-1:0]                  cnt_q;
	logic [lfu_pkg::CAP_BITS-1:0]   cap_q;
	logic                           req_cmd_q;
	logic [KB-1:0]                  req_key_q;
	logic [VB-1:0]                  req_value_q;
	logic                           m_tvalid_q;
	logic                           hit_q;
	logic                           evicted_q;
	logic [VB-1:0]                  read_value_q;
	logic [KB-1:0]                  evicted_key_q;

	lfu_pkg::scan_t                 scan_chain [NE+1];
	lfu_pkg::scan_t                 tail;
	lfu_pkg::upd_t                  upd_c;
	lfu_pkg::upd_t                  upd_bus;
	logic                           res_hit;
	logic                           res_ev;
	logic [VB-1:0]                  res_rd;
	logic [KB-1:0]                  res_evk;
	logic [31:0]                    cap_w;
	logic [31:0]                    used_w;
	logic                           out_free;
	logic                           fire;

	assign scan_chain[0] = '0;
	assign tail          = scan_chain[NE];

	for (genvar i = 0; i < NE; i++) begin : g_cell
		lfu_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (IB'(i)),
			.req_key  (req_key_q),
			.scan_in  (scan_chain[i]),
			.scan_out (scan_chain[i+1]),
			.upd      (upd_bus)
		);
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign fire     = (state_q == ST_COMMIT) && out_free;
	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cap_w = 32'(cap_q);
		if (cap_w == 32'd0) begin
			cap_w = 32'd1;
		end
		if (cap_w > 32'(NE)) begin
			cap_w = 32'(NE);
		end
		used_w = 32'(tail.used);

		upd_c          = '0;
		upd_c.op       = lfu_pkg::OP_NONE;
		upd_c.key      = req_key_q;
		upd_c.value    = req_value_q;
		upd_c.wr_value = (req_cmd_q == lfu_pkg::CMD_PUT);
		res_hit        = 1'b0;
		res_ev         = 1'b0;
		res_rd         = '1;
		res_evk        = '0;

		if (tail.found) begin
			upd_c.op       = lfu_pkg::OP_HIT;
			upd_c.slot     = tail.found_idx;
			upd_c.old_rank = UB'(tail.found_rank);
			res_hit        = 1'b1;
			if (req_cmd_q == lfu_pkg::CMD_GET) begin
				res_rd = tail.found_value;
			end
		end else if (req_cmd_q == lfu_pkg::CMD_PUT) begin
			if (used_w >= cap_w && tail.best_ok) begin
				upd_c.op       = lfu_pkg::OP_INSERT;
				upd_c.slot     = tail.best_idx;
				upd_c.old_rank = UB'(tail.best_rank);
				res_ev         = 1'b1;
				res_evk        = tail.best_key;
			end else if (tail.free_ok) begin
				upd_c.op       = lfu_pkg::OP_INSERT;
				upd_c.slot     = tail.free_idx;
				upd_c.old_rank = tail.used;
			end
		end

		upd_bus = upd_c;
		if (!fire) begin
			upd_bus.op = lfu_pkg::OP_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == IB'(NE - 1)) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_cmd_q   <= s_tuser;
			req_key_q   <= s_tdata[KB-1:0];
			req_value_q <= s_tdata[KB+VB-1:KB];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lfu_pkg::CAP_BITS'(lfu_pkg::CAP_RESET);
		end else if (cfg_wen) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			hit_q         <= res_hit;
			evicted_q     <= res_ev;
			read_value_q  <= res_rd;
			evicted_key_q <= res_evk;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {evicted_key_q, read_value_q};
	assign m_tuser  = {evicted_q, hit_q};

`ifndef SYNTHESIS
	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_SCAN && cnt_q == '0))
		else $error("accepted request did not start a scan");

	a_hit_not_evict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("result reports both a hit and an eviction");

	a_evk_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[1]) |-> (m_tdata[lfu_pkg::DATA_BITS-1:VB] == '0))
		else $error("evicted key is not zero without an eviction");
`endif

endmodule

// ===== bench/tb_lfu_cache_table.sv =====
module tb_lfu_cache_table;

	localparam int     WATCHDOG_LIMIT = 4000;
	localparam int     HOLD_CYCLES    = 400;
	localparam int     SEGMENTS       = 12;
	localparam int     SEG_ITEMS      = 79;
	localparam int     POOL_KEYS      = 20;
	localparam longint COUNT_MAX      = (longint'(1) << lfu_pkg::COUNT_BITS) - 1;

	typedef struct packed {
		logic                           hit;
		logic [lfu_pkg::VALUE_BITS-1:0] read_value;
		logic                           evicted;
		logic [lfu_pkg::KEY_BITS-1:0]   evicted_key;
	} lookup_t;

	typedef struct {
		bit                             is_cfg;
		logic [lfu_pkg::CAP_BITS-1:0]   cap;
		logic                           cmd;
		logic [lfu_pkg::KEY_BITS-1:0]   key;
		logic [lfu_pkg::VALUE_BITS-1:0] value;
		bit                             typed;
		lookup_t                        want;
	} plan_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_wen;
	logic [lfu_pkg::CAP_BITS-1:0]   cfg_wdata;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [lfu_pkg::DATA_BITS-1:0]  s_tdata;   // key, value
	logic                           s_tuser;   // cmd
	logic                           m_tvalid;
	logic                           m_tready;
	logic [lfu_pkg::DATA_BITS-1:0]  m_tdata;   // read_value, evicted_key
	logic [1:0]                     m_tuser;   // hit, evicted

	lfu_cache_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	bit                             slot_valid [lfu_pkg::ENTRIES];
	logic [lfu_pkg::KEY_BITS-1:0]   slot_key   [lfu_pkg::ENTRIES];
	logic [lfu_pkg::VALUE_BITS-1:0] slot_value [lfu_pkg::ENTRIES];
	longint                         slot_uses  [lfu_pkg::ENTRIES];
	int                             slot_age   [lfu_pkg::ENTRIES];
	logic [lfu_pkg::CAP_BITS-1:0]   capacity_q;

	lookup_t               pending_results [$];
	plan_row_t             plan [$];
	int                    n_bad;
	int                    quiet_cycles;
	int                    src_idle_pct;
	int                    sink_idle_pct;
	bit                    hold_sink;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void make_recent(int s, int old_age);
		for (int i = 0; i < lfu_pkg::ENTRIES; i++)
			if (i != s && slot_valid[i] && slot_age[i] < old_age)
				slot_age[i]++;
		slot_age[s] = 0;
	endfunction

	// Applies one request to the shadow store and returns the response it must produce.
	function automatic lookup_t lfu_access(logic cmd, logic [lfu_pkg::KEY_BITS-1:0] key,
		logic [lfu_pkg::VALUE_BITS-1:0] value);
		lookup_t r;
		int      lim;
		int      used;
		int      found;
		int      victim;
		int      old_age;
		r.hit         = 1'b0;
		r.read_value  = '1;
		r.evicted     = 1'b0;
		r.evicted_key = '0;
		lim    = (capacity_q == 0) ? 1 :
			(capacity_q > lfu_pkg::ENTRIES) ? lfu_pkg::ENTRIES : int'(capacity_q);
		used   = 0;
		found  = -1;
		victim = -1;
		for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
			if (slot_valid[i]) begin
				used++;
				if (found < 0 && slot_key[i] == key)
					found = i;
			end
		end
		if (found >= 0) begin
			r.hit = 1'b1;
			if (cmd == lfu_pkg::CMD_GET)
				r.read_value = slot_value[found];
			else
				slot_value[found] = value;
			if (slot_uses[found] < COUNT_MAX)
				slot_uses[found]++;
			make_recent(found, slot_age[found]);
		end else if (cmd == lfu_pkg::CMD_PUT) begin
			old_age = used;
			if (used >= lim) begin
				for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
					if (slot_valid[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
						(slot_uses[i] == slot_uses[victim] && slot_age[i] > slot_age[victim])))
						victim = i;
				end
				if (victim >= 0) begin
					r.evicted     = 1'b1;
					r.evicted_key = slot_key[victim];
					old_age       = slot_age[victim];
				end
			end
			if (victim < 0)
				for (int i = 0; i < lfu_pkg::ENTRIES; i++)
					if (!slot_valid[i] && victim < 0)
						victim = i;
			if (victim >= 0) begin
				slot_valid[victim] = 1'b1;
				slot_key[victim]   = key;
				slot_value[victim] = value;
				slot_uses[victim]  = 1;
				make_recent(victim, old_age);
			end
		end
		return r;
	endfunction

	function automatic plan_row_t cfg_row(logic [lfu_pkg::CAP_BITS-1:0] v);
		plan_row_t r;
		r.is_cfg = 1'b1;
		r.cap    = v;
		r.cmd    = lfu_pkg::CMD_GET;
		r.key    = '0;
		r.value  = '0;
		r.typed  = 1'b0;
		r.want   = '0;
		return r;
	endfunction

	function automatic plan_row_t req_row(logic cmd, logic [lfu_pkg::KEY_BITS-1:0] key,
		logic [lfu_pkg::VALUE_BITS-1:0] value, bit typed = 1'b0, logic hit = 1'b0,
		logic [lfu_pkg::VALUE_BITS-1:0] rd = '1, logic ev = 1'b0,
		logic [lfu_pkg::KEY_BITS-1:0] evk = '0);
		plan_row_t r;
		r.is_cfg           = 1'b0;
		r.cap              = '0;
		r.cmd              = cmd;
		r.key              = key;
		r.value            = value;
		r.typed            = typed;
		r.want.hit         = hit;
		r.want.read_value  = rd;
		r.want.evicted     = ev;
		r.want.evicted_key = evk;
		return r;
	endfunction

	task automatic send_request(logic cmd, logic [lfu_pkg::KEY_BITS-1:0] key,
		logic [lfu_pkg::VALUE_BITS-1:0] value, bit typed, lookup_t want);
		lookup_t model;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {value, key};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		model = lfu_access(cmd, key, value);
		pending_results.push_back(typed ? want : model);
	endtask

	// The capacity register is only written once every outstanding request has drained.
	task automatic write_capacity(logic [lfu_pkg::CAP_BITS-1:0] v);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen    <= 1'b0;
		capacity_q  = v;
	endtask

	function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			n_bad++;
			$display("%0t %s mismatch: expected %h actual %h", $time, what, want, got);
		end
	endfunction

	always @(posedge clk) begin
		lookup_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				n_bad++;
				$display("%0t unexpected response: expected none actual tuser %b tdata %h",
					$time, m_tuser, m_tdata);
			end else begin
				want = pending_results.pop_front();
				check_field("hit", 32'(want.hit), 32'(m_tuser[0]));
				check_field("read_value", want.read_value,
					m_tdata[lfu_pkg::VALUE_BITS-1:0]);
				check_field("evicted", 32'(want.evicted), 32'(m_tuser[1]));
				check_field("evicted_key", want.evicted_key,
					m_tdata[lfu_pkg::VALUE_BITS +: lfu_pkg::KEY_BITS]);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL lfu_cache_table");
				$finish;
			end
		end
	end

	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_sink) begin
				m_tready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
				hold_sink = 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	initial begin
		logic [lfu_pkg::KEY_BITS-1:0]   key_pool [POOL_KEYS];
		logic [lfu_pkg::CAP_BITS-1:0]   seg_caps [SEGMENTS];
		logic [lfu_pkg::KEY_BITS-1:0]   key;
		logic [lfu_pkg::VALUE_BITS-1:0] value;
		logic                           cmd;

		n_bad         = 0;
		hold_sink     = 1'b0;
		src_idle_pct  = 13;
		sink_idle_pct = 84;
		arst_n    <= 1'b0;
		cfg_wen   <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= lfu_pkg::CMD_GET;

		capacity_q = lfu_pkg::CAP_BITS'(lfu_pkg::CAP_RESET);
		for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
			slot_valid[i] = 1'b0;
			slot_key[i]   = '0;
			slot_value[i] = '0;
			slot_uses[i]  = 0;
			slot_age[i]   = 0;
		end

		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7fff_ffff;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < POOL_KEYS; i++)
			key_pool[i] = $urandom;
		seg_caps = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd1, 5'd9, 5'd4, 5'd16, 5'd5, 5'd0, 5'd12, 5'd31};

		plan.push_back(req_row(lfu_pkg::CMD_GET, 32'h0000_0000, 32'h1234_5678,
			1, 0, '1, 0, 0));
		plan.push_back(req_row(lfu_pkg::CMD_PUT, 32'h8000_0000, 32'h7fff_ffff,
			1, 0, '1, 0, 0));
		plan.push_back(req_row(lfu_pkg::CMD_GET, 32'h8000_0000, 32'h0000_0000,
			1, 1, 32'h7fff_ffff, 0, 0));
		plan.push_back(req_row(lfu_pkg::CMD_PUT, 32'h7fff_ffff, 32'h8000_0000,
			1, 0, '1, 0, 0));
		plan.push_back(req_row(lfu_pkg::CMD_GET, 32'h7fff_ffff, 32'hffff_ffff,
			1, 1, 32'h8000_0000, 0, 0));
		plan.push_back(req_row(lfu_pkg::CMD_PUT, 32'h8000_0000, 32'hffff_ffff,
			1, 1, '1, 0, 0));
		plan.push_back(req_row(lfu_pkg::CMD_GET, 32'h8000_0000, 32'h0000_0000,
			1, 1, 32'hffff_ffff, 0, 0));
		plan.push_back(req_row(lfu_pkg::CMD_GET, 32'hffff_ffff, 32'h0000_0000,
			1, 0, '1, 0, 0));
		plan.push_back(req_row(lfu_pkg::CMD_PUT, 32'hffff_ffff, 32'h0000_0000,
			1, 0, '1, 0, 0));
		plan.push_back(cfg_row(5'd3));
		plan.push_back(req_row(lfu_pkg::CMD_PUT, 32'd5, 32'd55));
		plan.push_back(req_row(lfu_pkg::CMD_GET, 32'hffff_ffff, 32'd0));
		// Capacity drops below occupancy, so each new key now replaces exactly one entry.
		plan.push_back(cfg_row(5'd1));
		plan.push_back(req_row(lfu_pkg::CMD_PUT, 32'd6, 32'd66));
		plan.push_back(req_row(lfu_pkg::CMD_GET, 32'd5, 32'd0));
		plan.push_back(cfg_row(5'd0));
		plan.push_back(req_row(lfu_pkg::CMD_PUT, 32'd7, 32'd77));
		plan.push_back(req_row(lfu_pkg::CMD_PUT, 32'd7, 32'h8000_0000));
		plan.push_back(cfg_row(5'd31));
		plan.push_back(req_row(lfu_pkg::CMD_PUT, 32'd8, 32'd88));
		plan.push_back(req_row(lfu_pkg::CMD_PUT, 32'd9, 32'd99));
		plan.push_back(req_row(lfu_pkg::CMD_GET, 32'd9, 32'd0));
		plan.push_back(req_row(lfu_pkg::CMD_GET, 32'd8, 32'd0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_capacity(plan[i].cap);
			else
				send_request(plan[i].cmd, plan[i].key, plan[i].value, plan[i].typed,
					plan[i].want);
		end

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			if (seg == SEGMENTS / 3) begin
				src_idle_pct  = 84;
				sink_idle_pct = 13;
			end
			if (seg == 2 * SEGMENTS / 3) begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			write_capacity(seg_caps[seg]);
			if (seg == 2 * SEGMENTS / 3)
				hold_sink = 1'b1;
			for (int n = 0; n < SEG_ITEMS; n++) begin
				cmd = ($urandom_range(99) < 50) ? lfu_pkg::CMD_PUT : lfu_pkg::CMD_GET;
				if ($urandom_range(99) < 85)
					key = key_pool[$urandom_range(POOL_KEYS - 1)];
				else
					key = $urandom;
				case ($urandom_range(9))
					0: value = 32'h8000_0000;
					1: value = 32'h7fff_ffff;
					2: value = '1;
					3: value = '0;
					default: value = $urandom;
				endcase
				send_request(cmd, key, value, 1'b0, '0);
			end
		end

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (lfu_pkg::ENTRIES + 4) @(posedge clk);
		if (n_bad == 0)
			$display("PASS lfu_cache_table");
		else
			$display("FAIL lfu_cache_table");
		$finish;
	end

endmodule

// ===== lfu_cache_table.f =====
rtl/lfu_pkg.sv
rtl/lfu_cell.sv
rtl/lfu_cache_table.sv
bench/tb_lfu_cache_table.sv
